@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the branch predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Assertion clocked on a named clock and disabled while the reset is low.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default block clock and reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, prop, msg)

`endif

`endif

@@ sv/tgbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tgbp_pkg
// Types, constants and helper functions shared by the branch predictor.
// ----------------------------------------------------------------------------
package tgbp_pkg;

  // Default table sizes (index widths).
  localparam int unsigned GLOBAL_BITS_MAX_DEF = 15;
  localparam int unsigned LOCAL_BITS_MAX_DEF  = 15;
  localparam int unsigned PC_BITS_MAX_DEF     = 15;

  // Widest mask any width parameter can ask for.
  localparam int unsigned MASK_W = 20;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned WREG_W = 4;

  // Field widths.
  localparam int unsigned ADDRESS_W = 32;

  // Predictor modes.
  typedef enum logic [1:0] {
    MODE_STATIC     = 2'd0,
    MODE_GSHARE     = 2'd1,
    MODE_TOURNAMENT = 2'd2,
    MODE_CUSTOM     = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE        = 2'd0,
    REG_GLOBAL_BITS = 2'd1,
    REG_LOCAL_BITS  = 2'd2,
    REG_PC_BITS     = 2'd3
  } reg_idx_e;

  // Item kinds.
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_TRAIN   = 1'b1;

  // Two-bit counter values.
  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_WNT = 2'd1;
  localparam logic [1:0] CTR_WT  = 2'd2;
  localparam logic [1:0] CTR_MAX = 2'd3;

  // Reset values of the configuration registers.
  localparam mode_e       MODE_RST        = MODE_STATIC;
  localparam logic [3:0]  GLOBAL_BITS_RST = 4'd9;
  localparam logic [3:0]  LOCAL_BITS_RST  = 4'd10;
  localparam logic [3:0]  PC_BITS_RST     = 4'd10;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    mode_e              mode;
    logic [WREG_W-1:0]  global_bits;
    logic [WREG_W-1:0]  local_bits;
    logic [WREG_W-1:0]  pc_bits;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write reset values at the sweep index
    logic load;     // capture an accepted transaction
    logic rd_hist;  // read local history, global and chooser counters
    logic rd_lctr;  // read the local counter selected by the history
    logic commit;   // register the result and write back on training
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } status_t;

  // Mask of the effective width: registers of zero act as one, values
  // above the table width and custom mode use the table width.
  function automatic logic [MASK_W-1:0] width_mask(input logic [WREG_W-1:0] r,
                                                   input int unsigned maxb,
                                                   input logic custom);
    int unsigned       b;
    logic [MASK_W-1:0] m;
    b = 32'(r);
    if (custom || b > maxb) b = maxb;
    if (b < 1) b = 1;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      m[i] = (i < b);
    end
    return m;
  endfunction

  // Saturating two-bit counter step.
  function automatic logic [1:0] bump(input logic [1:0] c, input logic t);
    logic [1:0] r;
    if (t) r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    else   r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    return r;
  endfunction

endpackage

@@ sv/tgbp_ram.sv @@
// ----------------------------------------------------------------------------
// tgbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tgbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tgbp_cfg.sv @@
// ----------------------------------------------------------------------------
// tgbp_cfg
// APB-style configuration register file: mode and the global, local and pc widths.
// ----------------------------------------------------------------------------
module tgbp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgbp_pkg::DATA_W-1:0]  pwdata,
  output logic [tgbp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tgbp_pkg::cfg_t               cfg_o
);
  import tgbp_pkg::*;

  mode_e             mode_q;
  logic [WREG_W-1:0] global_bits_q;
  logic [WREG_W-1:0] local_bits_q;
  logic [WREG_W-1:0] pc_bits_q;
  logic              wr_en;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_RST;
      global_bits_q <= GLOBAL_BITS_RST;
      local_bits_q  <= LOCAL_BITS_RST;
      pc_bits_q     <= PC_BITS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:        mode_q        <= mode_e'(pwdata[1:0]);
        REG_GLOBAL_BITS: global_bits_q <= pwdata[WREG_W-1:0];
        REG_LOCAL_BITS:  local_bits_q  <= pwdata[WREG_W-1:0];
        REG_PC_BITS:     pc_bits_q     <= pwdata[WREG_W-1:0];
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      REG_MODE:        prdata = DATA_W'(mode_q);
      REG_GLOBAL_BITS: prdata = DATA_W'(global_bits_q);
      REG_LOCAL_BITS:  prdata = DATA_W'(local_bits_q);
      REG_PC_BITS:     prdata = DATA_W'(pc_bits_q);
    endcase
  end

  assign cfg_o.mode        = mode_q;
  assign cfg_o.global_bits = global_bits_q;
  assign cfg_o.local_bits  = local_bits_q;
  assign cfg_o.pc_bits     = pc_bits_q;

endmodule

@@ sv/tgbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgbp_ctrl
// Controller: clearing sweep after reset, then the read, read, commit
// sequence for each transaction, and the output valid register.
// ----------------------------------------------------------------------------
module tgbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tgbp_pkg::status_t status_i,
  output tgbp_pkg::cmd_t    cmd_o
);
  import tgbp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_HIST,
    S_RD_LCTR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state, commands and output valid.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_HIST;
        end
      end
      S_RD_HIST: begin
        cmd_o.rd_hist = 1'b1;
        state_d       = S_RD_LCTR;
      end
      S_RD_LCTR: begin
        cmd_o.rd_lctr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // Finish only once the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/tgbp_dp.sv @@
// ----------------------------------------------------------------------------
// tgbp_dp
// Datapath: transaction registers, global history, the four counter and
// history tables, prediction and training update logic.
// ----------------------------------------------------------------------------
module tgbp_dp #(
  parameter int unsigned GLOBAL_BITS_MAX = tgbp_pkg::GLOBAL_BITS_MAX_DEF,
  parameter int unsigned LOCAL_BITS_MAX  = tgbp_pkg::LOCAL_BITS_MAX_DEF,
  parameter int unsigned PC_BITS_MAX     = tgbp_pkg::PC_BITS_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tgbp_pkg::cfg_t                 cfg_i,
  input  tgbp_pkg::cmd_t                 cmd_i,
  output tgbp_pkg::status_t              status_o,
  input  logic                           kind_i,
  input  logic [tgbp_pkg::ADDRESS_W-1:0] branch_address_i,
  input  logic                           taken_i,
  output logic                           prediction_o
);
  import tgbp_pkg::*;

  localparam int unsigned G = GLOBAL_BITS_MAX;
  localparam int unsigned L = LOCAL_BITS_MAX;
  localparam int unsigned P = PC_BITS_MAX;
  localparam int unsigned PC_W = (G > P) ? G : P;
  localparam int unsigned GL_W = (G > L) ? G : L;
  localparam int unsigned CLR_W = (GL_W > P) ? GL_W : P;

  // Transaction registers.
  logic            kind_q;
  logic [PC_W-1:0] pc_q;
  logic            taken_q;
  logic            prediction_q;

  logic [G-1:0]     ghist_q, ghist_d;
  logic [CLR_W-1:0] clr_q;

  logic              custom;
  logic [MASK_W-1:0] gmask_w, lmask_w, pmask_w;
  logic [G-1:0]      gmask;
  logic [L-1:0]      lmask;
  logic [P-1:0]      pmask;

  logic [P-1:0] hidx;
  logic [G-1:0] gidx;
  logic [L-1:0] lidx;

  logic [L-1:0] lhist_rd, lhist_next;
  logic [1:0]   gctr_rd, chr_rd, lctr_rd, chr_next;
  logic         local_p, global_p, pred;
  logic         upd_g, upd_t;

  // Capture the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      pc_q    <= branch_address_i[PC_W-1:0];
      taken_q <= taken_i;
    end
    if (cmd_i.commit) begin
      prediction_q <= (kind_q == KIND_TRAIN) ? 1'b0 : pred;
    end
  end

  // Effective width masks.
  assign custom  = (cfg_i.mode == MODE_CUSTOM);
  assign gmask_w = width_mask(cfg_i.global_bits, G, custom);
  assign lmask_w = width_mask(cfg_i.local_bits, L, custom);
  assign pmask_w = width_mask(cfg_i.pc_bits, P, custom);
  assign gmask   = gmask_w[G-1:0];
  assign lmask   = lmask_w[L-1:0];
  assign pmask   = pmask_w[P-1:0];

  // Table indexes; tournament mode uses plain history, the others XOR it with the pc.
  assign hidx = pc_q[P-1:0] & pmask;
  assign gidx = (cfg_i.mode == MODE_TOURNAMENT) ? (ghist_q & gmask)
                                                : ((ghist_q ^ pc_q[G-1:0]) & gmask);
  assign lidx = lhist_rd & lmask;

  // Prediction from the counters read.
  assign local_p  = lctr_rd[1];
  assign global_p = gctr_rd[1];
  always_comb begin
    unique case (cfg_i.mode)
      MODE_STATIC:     pred = 1'b1;
      MODE_GSHARE:     pred = global_p;
      MODE_TOURNAMENT: pred = chr_rd[1] ? global_p : local_p;
      MODE_CUSTOM:     pred = chr_rd[1] ? global_p : local_p;
    endcase
  end

  // Chooser moves toward the side that alone was right.
  always_comb begin
    if (local_p == taken_q && global_p != taken_q && chr_rd != CTR_MIN) begin
      chr_next = chr_rd - 2'd1;
    end else if (global_p == taken_q && local_p != taken_q && chr_rd != CTR_MAX) begin
      chr_next = chr_rd + 2'd1;
    end else begin
      chr_next = chr_rd;
    end
  end

  assign lhist_next = {lhist_rd[L-2:0], taken_q} & lmask;

  // Training write enables.
  assign upd_g = cmd_i.commit && (kind_q == KIND_TRAIN) && (cfg_i.mode != MODE_STATIC);
  assign upd_t = upd_g && (cfg_i.mode != MODE_GSHARE);

  // Global history and clearing sweep counter.
  assign ghist_d = {ghist_q[G-2:0], taken_q} & gmask;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghist_q <= '0;
      clr_q   <= '0;
    end else begin
      if (upd_g) ghist_q <= ghist_d;
      if (cmd_i.clear) clr_q <= clr_q + CLR_W'(1);
    end
  end

  assign status_o.clear_last = &clr_q;

  // Global counters.
  tgbp_ram #(.WIDTH(2), .DEPTH(2 ** G)) u_gctr (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || upd_g),
    .waddr_i (cmd_i.clear ? clr_q[G-1:0] : gidx),
    .wdata_i (cmd_i.clear ? CTR_WNT : bump(gctr_rd, taken_q)),
    .re_i    (cmd_i.rd_hist),
    .raddr_i (gidx),
    .rdata_o (gctr_rd)
  );

  // Chooser counters.
  tgbp_ram #(.WIDTH(2), .DEPTH(2 ** G)) u_chooser (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || upd_t),
    .waddr_i (cmd_i.clear ? clr_q[G-1:0] : gidx),
    .wdata_i (cmd_i.clear ? CTR_WT : chr_next),
    .re_i    (cmd_i.rd_hist),
    .raddr_i (gidx),
    .rdata_o (chr_rd)
  );

  // Local histories, one per pc index.
  tgbp_ram #(.WIDTH(L), .DEPTH(2 ** P)) u_lhist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || upd_t),
    .waddr_i (cmd_i.clear ? clr_q[P-1:0] : hidx),
    .wdata_i (cmd_i.clear ? '0 : lhist_next),
    .re_i    (cmd_i.rd_hist),
    .raddr_i (hidx),
    .rdata_o (lhist_rd)
  );

  // Local counters, indexed by the local history.
  tgbp_ram #(.WIDTH(2), .DEPTH(2 ** L)) u_lctr (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || upd_t),
    .waddr_i (cmd_i.clear ? clr_q[L-1:0] : lidx),
    .wdata_i (cmd_i.clear ? CTR_WNT : bump(lctr_rd, taken_q)),
    .re_i    (cmd_i.rd_lctr),
    .raddr_i (lidx),
    .rdata_o (lctr_rd)
  );

  assign prediction_o = prediction_q;

endmodule

@@ sv/tournament_gshare_branch_predictor_top.sv @@
// ----------------------------------------------------------------------------
// tournament_gshare_branch_predictor_top
// Branch predictor with static, gshare, tournament and custom hybrid modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries predict or train
//   transactions: kind_i, branch_address_i and taken_i. Output channel
//   (out_valid_o / out_stall_i) returns one prediction_o per transaction,
//   zero for training transactions.
//   An accepted transaction passes through the local history read, the local
//   counter read that depends on it, and the commit, which registers the
//   result; the block accepts no new transaction until that commit is done,
//   as in_stall_o stays high from acceptance until then.
//   The result waits in an output register; the next transaction is
//   accepted while it waits, and its commit holds until the register frees.
//   After reset the tables are swept to their initial values, one entry per
//   cycle, through 2**max(GLOBAL_BITS_MAX, LOCAL_BITS_MAX, PC_BITS_MAX) sweep
//   indexes (32768 by default) with in_stall_o high. Configuration writes over the
//   APB port are taken at any time and should be made while the block idles.
// ----------------------------------------------------------------------------
module tournament_gshare_branch_predictor_top #(
  parameter int unsigned GLOBAL_BITS_MAX = tgbp_pkg::GLOBAL_BITS_MAX_DEF,
  parameter int unsigned LOCAL_BITS_MAX  = tgbp_pkg::LOCAL_BITS_MAX_DEF,
  parameter int unsigned PC_BITS_MAX     = tgbp_pkg::PC_BITS_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tgbp_pkg::ADDR_W-1:0]    paddr,
  input  logic [tgbp_pkg::DATA_W-1:0]    pwdata,
  output logic [tgbp_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [tgbp_pkg::ADDRESS_W-1:0] branch_address_i,
  input  logic                           taken_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           prediction_o
);
  import tgbp_pkg::*;

  `include "assert_macros.svh"

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  tgbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Controller.
  tgbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  tgbp_dp #(
    .GLOBAL_BITS_MAX (GLOBAL_BITS_MAX),
    .LOCAL_BITS_MAX  (LOCAL_BITS_MAX),
    .PC_BITS_MAX     (PC_BITS_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .branch_address_i (branch_address_i),
    .taken_i          (taken_i),
    .prediction_o     (prediction_o)
  );

  // No transaction is taken while the tables are being swept.
  `ASSERT_CLK(a_clear_stalls, cmd.clear |-> in_stall_o, "transaction accepted during clear")
  // An accepted transaction starts its table reads in the next cycle.
  `ASSERT_CLK(a_accept_reads, (in_valid_i && !in_stall_o) |=> cmd.rd_hist, "read not started")
  // A commit never overwrites a result that is still stalled.
  `ASSERT_CLK(a_no_overwrite, cmd.commit |-> !(out_valid_o && out_stall_i), "result lost")
  // A commit always presents a result in the following cycle.
  `ASSERT_CLK(a_commit_valid, cmd.commit |=> out_valid_o, "result not presented")

endmodule
